/* rtl/core/lrg_pkg.sv */
// Shared types and constants for the linear ramp generator.
// Configuration register indexes, reset values and controller/datapath links.
// No dependencies.
package lrg_pkg;

  // Configuration register widths
  localparam int LEN_W = 16;
  localparam int SPT_W = 9;
  localparam int CFG_W = 16;
  localparam int IDX_W = 1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_RAMP_SAMPLES = 1'd0;
  localparam logic [IDX_W-1:0] REG_TICK_SAMPLES = 1'd1;

  // Register reset values
  localparam logic [LEN_W-1:0] RAMP_SAMPLES_RST = 16'd4800;
  localparam logic [SPT_W-1:0] TICK_SAMPLES_RST = 9'd1;

  // Input op codes
  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_SET_DEST = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic take_tick;  // apply one tick step on this transfer
    logic take_set;   // latch destination, form difference
    logic mul;        // scale magnitude by samples per tick, load divider
    logic div_step;   // one restoring division step
    logic fin;        // saturate quotient, write new step
    logic out_load;   // load the output register
  } lrg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_last;   // current division step is the final one
  } lrg_status_t;

endpackage

/* rtl/core/lrg_if.sv */
// Stream interfaces for the linear ramp generator input and result channels.
// Valid/ready handshake with payload; no package dependency.
interface lrg_in_if #(
  parameter int VALUE_BITS = 24
) ();
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic signed [VALUE_BITS-1:0] target;

  modport source (output valid, output op, output target, input ready);
  modport sink   (input valid, input op, input target, output ready);
endinterface

interface lrg_out_if #(
  parameter int VALUE_BITS = 24
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         moving;

  modport source (output valid, output value, output moving, input ready);
  modport sink   (input valid, input value, input moving, output ready);
endinterface

/* rtl/core/lrg_ctrl.sv */
// Sequencing state machine for the linear ramp generator.
// Depends on lrg_pkg for command and status structs.
module lrg_ctrl
  import lrg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_op,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output lrg_cmd_t    cmd,
  input  lrg_status_t status
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_FIN  = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t state, state_next;

  // Decode state into commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_SET_DEST) begin
            cmd.take_set = 1'b1;
            state_next   = S_MUL;
          end else begin
            cmd.take_tick = 1'b1;
            state_next    = S_HOLD;
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        // Wait for a free output slot
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold output valid until the result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(cmd.out_load && out_valid && !out_ready))
    else $error("output register overwritten while full");

  a_set_to_mul: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_op == OP_SET_DEST)) |=> (state == S_MUL))
    else $error("set destination did not start the multiply");

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !status.div_last) |=> (state == S_DIV))
    else $error("division left early");
`endif

endmodule

/* rtl/core/lrg_datapath.sv */
// Datapath of the linear ramp generator: config registers, accumulator,
// step multiply, restoring divider and output register. Uses lrg_pkg.
module lrg_datapath
  import lrg_pkg::*;
#(
  parameter int VALUE_BITS      = 24,
  parameter int EXTRA_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lrg_cmd_t                     cmd,
  output lrg_status_t                  status,
  input  logic                         wr_en,
  input  logic [IDX_W-1:0]             wr_index,
  input  logic [CFG_W-1:0]             wr_data,
  input  logic signed [VALUE_BITS-1:0] target,
  output logic signed [VALUE_BITS-1:0] value,
  output logic                         moving
);

  localparam int ACC_W  = VALUE_BITS + EXTRA_FRAC_BITS;
  localparam int PROD_W = ACC_W + SPT_W;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);
  localparam logic [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

  logic [LEN_W-1:0]             ramp_samples;
  logic [SPT_W-1:0]             tick_samples;
  logic signed [ACC_W-1:0]      current;
  logic signed [ACC_W-1:0]      step;
  logic signed [VALUE_BITS-1:0] destination;
  logic [ACC_W-1:0]             mag;
  logic                         neg;
  logic [PROD_W-1:0]            dvd;
  logic [LEN_W-1:0]             rem;
  logic [CNT_W-1:0]             cnt;

  logic [LEN_W-1:0]        len_eff;
  logic signed [ACC_W-1:0] target_acc;
  logic signed [ACC_W-1:0] dest_acc;
  logic [ACC_W:0]          diff;
  logic [ACC_W:0]          diff_abs;
  logic [ACC_W:0]          sum;
  logic signed [ACC_W-1:0] current_next;
  logic                    reached;
  logic [PROD_W-1:0]       prod;
  logic [LEN_W:0]          trial;
  logic [LEN_W:0]          trial_sub;
  logic                    trial_ge;
  logic [ACC_W-1:0]        limit;
  logic                    q_big;
  logic [ACC_W-1:0]        q_sat;

  // Zero length counts as one sample
  assign len_eff = (ramp_samples == '0) ? LEN_W'(1) : ramp_samples;

  assign target_acc = {target, {EXTRA_FRAC_BITS{1'b0}}};
  assign dest_acc   = {destination, {EXTRA_FRAC_BITS{1'b0}}};

  // Signed difference to the new destination and its magnitude
  assign diff     = {target_acc[ACC_W-1], target_acc} - {current[ACC_W-1], current};
  assign diff_abs = diff[ACC_W] ? (~diff + 1'b1) : diff;

  // Tick sum with saturation, then arrival check in direction of travel
  assign sum = {current[ACC_W-1], current} + {step[ACC_W-1], step};
  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      current_next = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      current_next = sum[ACC_W-1:0];
    end
  end
  assign reached = (!step[ACC_W-1] && (step != '0) && (current_next >= dest_acc)) ||
                   (step[ACC_W-1] && (current_next <= dest_acc));

  // Magnitude times samples per tick
  assign prod = {{SPT_W{1'b0}}, mag} * {{ACC_W{1'b0}}, tick_samples};

  // One restoring division step
  assign trial     = {rem, dvd[PROD_W-1]};
  assign trial_sub = trial - {1'b0, len_eff};
  assign trial_ge  = (trial >= {1'b0, len_eff});

  // Quotient limit depends on direction
  assign limit = neg ? ACC_MIN : ACC_MAX;
  assign q_big = (dvd[PROD_W-1:ACC_W] != '0) || (dvd[ACC_W-1:0] > limit);
  assign q_sat = q_big ? limit : dvd[ACC_W-1:0];

  assign status.div_last = (cnt == CNT_LAST);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_samples <= RAMP_SAMPLES_RST;
      tick_samples <= TICK_SAMPLES_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_RAMP_SAMPLES: ramp_samples <= wr_data[LEN_W-1:0];
        REG_TICK_SAMPLES: tick_samples <= wr_data[SPT_W-1:0];
        default: ;
      endcase
    end
  end

  // Ramp state
  always_ff @(posedge clk) begin
    if (rst) begin
      current     <= '0;
      step        <= '0;
      destination <= '0;
    end else begin
      if (cmd.take_tick) begin
        current <= current_next;
        if (reached) begin
          step <= '0;
        end
      end
      if (cmd.take_set) begin
        destination <= target;
      end
      if (cmd.fin) begin
        step <= neg ? (~q_sat + 1'b1) : q_sat;
      end
    end
  end

  // Step computation: difference, multiply, divide
  always_ff @(posedge clk) begin
    if (cmd.take_set) begin
      mag <= diff_abs[ACC_W-1:0];
      neg <= diff[ACC_W];
    end
    if (cmd.mul) begin
      dvd <= prod;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[PROD_W-2:0], trial_ge};
      rem <= trial_ge ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
      cnt <= cnt + 1'b1;
    end
  end

  // Output register: top bits of the accumulator
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value  <= current[ACC_W-1:EXTRA_FRAC_BITS];
      moving <= (step != '0);
    end
  end

`ifndef SYNTH
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < len_eff))
    else $error("divider remainder out of range");

  a_step_sign: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> ((step == '0) || (step[ACC_W-1] == neg)))
    else $error("step sign does not match direction");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_tick && (step == '0)) |=> $stable(current))
    else $error("value moved with a zero step");
`endif

endmodule

/* rtl/core/linear_ramp_generator_unit.sv */
// Top level of the linear ramp generator: controller plus datapath.
// Depends on lrg_pkg, lrg_if, lrg_ctrl and lrg_datapath.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        op, target
//   out_ch    out  valid/ready        value, moving
//   config    in   wr_en (no wait)    wr_index, wr_data
//
// A tick updates the value, then loads the output before ready returns.
// A set destination runs multiply, divide and finish, then loads the output,
// with the one-bit-per-cycle restoring divider over the scaled magnitude.
// Synchronous active-high reset clears state and loads register defaults.
// A result waiting in the output register does not block the next input
// transfer; the block stalls in its output stage only if a second result is due.
module linear_ramp_generator_unit
  import lrg_pkg::*;
#(
  parameter int VALUE_BITS      = 24,
  parameter int EXTRA_FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  lrg_in_if.sink           in_ch,
  lrg_out_if.source        out_ch,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0] wr_data
);

  lrg_cmd_t    cmd;
  lrg_status_t status;

  // Sequencer
  lrg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Arithmetic and state
  lrg_datapath #(
    .VALUE_BITS      (VALUE_BITS),
    .EXTRA_FRAC_BITS (EXTRA_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .target   (in_ch.target),
    .value    (out_ch.value),
    .moving   (out_ch.moving)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for linear_ramp_generator_unit: ramp slope, tick and retarget behavior.
// Drives lrg_in_if/lrg_out_if and the register write port, predicts every result in a local ramp model.
// Depends on lrg_pkg, lrg_if and the linear_ramp_generator_unit RTL.
module tb_top;
  import lrg_pkg::*;

  localparam int VB    = 24;
  localparam int EFB   = 16;
  localparam int ACC_W = VB + EFB;
  localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic signed [VB-1:0] value;
    logic                 moving;
  } ramp_level_t;

  logic             clk;
  logic             rst;
  logic             wr_en;
  logic [IDX_W-1:0] wr_index;
  logic [CFG_W-1:0] wr_data;

  lrg_in_if  #(.VALUE_BITS(VB)) in_ch ();
  lrg_out_if #(.VALUE_BITS(VB)) out_ch ();

  linear_ramp_generator_unit #(
    .VALUE_BITS     (VB),
    .EXTRA_FRAC_BITS(EFB)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data)
  );

  // Ramp model state
  logic [LEN_W-1:0] model_len;
  logic [SPT_W-1:0] model_spt;
  longint           model_acc;
  longint           model_slope;
  longint           model_dest;
  ramp_level_t      pending_levels[$];

  int fail_count;
  int items_sent;
  int idle_cycles;
  int rx_stall;
  bit idle_on;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Per-tick increment: (dest - acc) * spt / len, truncated toward zero, saturated
  function automatic longint slope_for(longint acc, longint dest,
                                       logic [LEN_W-1:0] len_reg,
                                       logic [SPT_W-1:0] spt_reg);
    longint      diff;
    bit          neg;
    logic [63:0] mag;
    logic [63:0] len;
    logic [63:0] spt;
    logic [63:0] lim;
    logic [63:0] qa;
    logic [63:0] ra;
    logic [63:0] q;
    diff = dest * (longint'(1) <<< EFB) - acc;
    neg  = diff < 0;
    mag  = neg ? 64'(-diff) : 64'(diff);
    len  = (len_reg == '0) ? 64'd1 : 64'(len_reg);
    spt  = 64'(spt_reg);
    lim  = neg ? 64'(ACC_MAX) + 64'd1 : 64'(ACC_MAX);
    qa   = mag / len;
    ra   = mag % len;
    if (spt == 64'd0) begin
      q = 64'd0;
    end else if (qa > lim / spt) begin
      q = lim;
    end else begin
      q = qa * spt + (ra * spt) / len;
      if (q > lim) q = lim;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Advance the model by one accepted item and queue the result it causes
  task automatic apply_ramp_item(logic op, logic signed [VB-1:0] tgt);
    longint      dest_acc;
    logic [63:0] acc_bits;
    ramp_level_t lvl;
    if (op == OP_SET_DEST) begin
      model_dest  = tgt;
      model_slope = slope_for(model_acc, model_dest, model_len, model_spt);
    end else begin
      dest_acc  = model_dest * (longint'(1) <<< EFB);
      model_acc = model_acc + model_slope;
      if (model_acc > ACC_MAX) model_acc = ACC_MAX;
      if (model_acc < ACC_MIN) model_acc = ACC_MIN;
      if ((model_slope > 0 && model_acc >= dest_acc) ||
          (model_slope < 0 && model_acc <= dest_acc)) begin
        model_slope = 0;
      end
    end
    acc_bits   = model_acc;
    lvl.value  = acc_bits[ACC_W-1:EFB];
    lvl.moving = (model_slope != 0);
    pending_levels.push_back(lvl);
  endtask

  // Present one item after a random gap and hold it until the transfer
  task automatic send_item(logic op, logic signed [VB-1:0] tgt);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid  = 1'b1;
    in_ch.op     = op;
    in_ch.target = tgt;
    do @(posedge clk); while (!in_ch.ready);
    apply_ramp_item(op, tgt);
    items_sent++;
  endtask

  // Drop valid and hold until every expected result has been seen
  task automatic quiesce();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = data;
    @(negedge clk);
    wr_en = 1'b0;
    if (idx == REG_RAMP_SAMPLES) model_len = data[LEN_W-1:0];
    else model_spt = data[SPT_W-1:0];
  endtask

  // Reprogram both registers on an idle block; junk in the unused upper bits of spt
  task automatic set_ramp_config(logic [LEN_W-1:0] len, logic [SPT_W-1:0] spt);
    logic [CFG_W-1:0] spt_word;
    spt_word = CFG_W'($urandom);
    spt_word[SPT_W-1:0] = spt;
    quiesce();
    write_reg(REG_RAMP_SAMPLES, CFG_W'(len));
    write_reg(REG_TICK_SAMPLES, spt_word);
  endtask

  task automatic test_reset_config();
    send_item(OP_SET_DEST, 24'sh7FFFFF);
    send_item(OP_TICK, '0);
    send_item(OP_TICK, '0);
    send_item(OP_SET_DEST, -24'sh800000);
    send_item(OP_TICK, '0);
  endtask

  // Saturated slope, accumulator saturation both ways, zero-distance retarget
  task automatic test_saturation();
    set_ramp_config(16'd1, 9'd256);
    send_item(OP_SET_DEST, 24'sh7FFFFF);
    send_item(OP_TICK, '0);
    send_item(OP_SET_DEST, -24'sh800000);
    send_item(OP_TICK, '0);
    send_item(OP_TICK, '0);
    send_item(OP_SET_DEST, -24'sh800000);
    send_item(OP_TICK, '0);
  endtask

  task automatic test_long_ramp();
    set_ramp_config(16'd65535, 9'd1);
    send_item(OP_SET_DEST, 24'sh000001);
    send_item(OP_TICK, '0);
    set_ramp_config(16'd65535, 9'd256);
    send_item(OP_SET_DEST, 24'sh400000);
    send_item(OP_TICK, '0);
  endtask

  // Length change while a ramp runs: old slope holds until the next retarget
  task automatic test_length_change();
    set_ramp_config(16'd8, 9'd1);
    send_item(OP_SET_DEST, 24'sh010000);
    send_item(OP_TICK, '0);
    send_item(OP_TICK, '0);
    quiesce();
    write_reg(REG_RAMP_SAMPLES, 16'd2);
    send_item(OP_TICK, '0);
    send_item(OP_SET_DEST, 24'sh020000);
    send_item(OP_TICK, '0);
    send_item(OP_TICK, '0);
  endtask

  function automatic logic signed [VB-1:0] pick_target();
    logic [63:0]          acc_bits;
    logic signed [VB-1:0] here;
    acc_bits = model_acc;
    here     = acc_bits[ACC_W-1:EFB];
    case ($urandom_range(0, 5))
      0:       return 24'sh7FFFFF;
      1:       return -24'sh800000;
      2, 3:    return here + VB'($urandom_range(0, 8191)) - VB'(4096);
      default: return VB'($urandom);
    endcase
  endfunction

  task automatic test_random_ramps();
    int               stop_at;
    int               ramps;
    int               cap;
    int               n;
    logic [LEN_W-1:0] len;
    logic [SPT_W-1:0] spt;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       len = 16'd65535;
        1:       len = 16'd1;
        default: len = LEN_W'($urandom_range(1, 400));
      endcase
      case ($urandom_range(0, 9))
        0:       spt = 9'd256;
        1:       spt = 9'd1;
        default: spt = SPT_W'($urandom_range(1, 256));
      endcase
      set_ramp_config(len, spt);
      ramps = $urandom_range(1, 4);
      repeat (ramps) begin
        if ($urandom_range(0, 4) == 0) begin
          // Noise: unordered mix of ticks and retargets
          repeat (10) send_item(logic'($urandom_range(0, 1)), VB'($urandom));
        end else begin
          // Well-formed ramp: retarget, then tick until settled or cut short
          send_item(OP_SET_DEST, pick_target());
          cap = $urandom_range(1, 40);
          n   = 0;
          while (model_slope != 0 && n < cap) begin
            send_item(OP_TICK, VB'($urandom));
            n++;
          end
          repeat ($urandom_range(0, 2)) send_item(OP_TICK, VB'($urandom));
        end
      end
    end
  endtask

  // Result checker and stall watchdog
  always @(posedge clk) begin : check_levels
    ramp_level_t want;
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        if (pending_levels.size() == 0) begin
          $error("unexpected result: value %0d moving %0b", out_ch.value, out_ch.moving);
          fail_count++;
        end else begin
          want = pending_levels.pop_front();
          if (out_ch.value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, out_ch.value);
            fail_count++;
          end
          if (out_ch.moving !== want.moving) begin
            $error("moving: expected %0b, actual %0b", want.moving, out_ch.moving);
            fail_count++;
          end
        end
        rx_stall = idle_on ? $urandom_range(0, 9) : 0;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result-side backpressure
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      out_ch.ready = 1'b0;
      rx_stall--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  initial begin
    rst          = 1'b1;
    wr_en        = 1'b0;
    wr_index     = REG_RAMP_SAMPLES;
    wr_data      = '0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_TICK;
    in_ch.target = '0;
    out_ch.ready = 1'b0;
    model_len    = RAMP_SAMPLES_RST;
    model_spt    = TICK_SAMPLES_RST;
    model_acc    = 0;
    model_slope  = 0;
    model_dest   = 0;
    fail_count   = 0;
    items_sent   = 0;
    idle_cycles  = 0;
    rx_stall     = 0;
    idle_on      = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_config();
    test_saturation();
    test_long_ramp();
    test_length_change();
    test_random_ramps();

    // Drain, then let the pipeline settle
    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_levels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/lrg_pkg.sv
rtl/core/lrg_if.sv
rtl/core/lrg_ctrl.sv
rtl/core/lrg_datapath.sv
rtl/core/linear_ramp_generator_unit.sv
tb/tb_top.sv
